FILE: rtl/core/tcc_pkg.sv
package tcc_pkg;

  // coordinate and intermediate widths, all exact
  localparam int CW  = 32;   // Q16.16 coordinate
  localparam int DW  = 33;   // corner difference
  localparam int SQW = 65;   // squared difference, unsigned
  localparam int LW  = 66;   // squared edge length, unsigned
  localparam int SW  = 68;   // edge-length combination, signed
  localparam int WW  = 135;  // barycentric weight, signed
  localparam int TW  = 137;  // weight total, signed
  localparam int XPW = 168;  // weight times difference, signed
  localparam int XW  = 169;  // numerator, signed
  localparam int RW  = 170;  // divider remainder and shifted divisor
  localparam int QB  = 35;   // quotient magnitude bits, top bit flags overflow
  localparam int QW  = 37;   // signed floor quotient

  typedef logic [RW-1:0] rem_t;

  // one divider step: shared divisor, three lanes of remainder and quotient
  typedef struct packed {
    rem_t                  t;
    rem_t [2:0]            r;
    logic [2:0][QB-1:0]    q;
  } div_t;

endpackage

FILE: rtl/core/tcc_mul.sv
// Signed multiplier as a row of cells, one 32-bit slice of b per cell.
// Registered at the input, in each cell, at the final sum and at the output. WB must be at least 33.
module tcc_mul #(
  parameter int WA = 68,
  parameter int WB = 67
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NA  = (WA + 31) / 32;
  localparam int NH  = (NA + 1) / 2;
  localparam int AW  = NH * 64;
  localparam int NB  = (WB + 31) / 32;
  localparam int BW  = NB * 32;
  localparam int ACW = AW + BW;
  localparam int PW  = WA + WB;

  logic [WA-1:0]  a_abs;
  logic [WB-1:0]  b_abs;
  logic [AW-1:0]  am;
  logic [BW-1:0]  bm;
  logic           sg;

  logic [ACW-1:0] acc   [NB];
  logic [AW-1:0]  ev    [NB];
  logic [AW-1:0]  od    [NB];
  logic           sg_s  [NB];
  logic [AW-1:0]  am_s  [NB-1];
  logic [BW-1:0]  bm_s  [NB-1];

  logic [ACW-1:0] fin;
  logic           sg_f;
  logic [PW-1:0]  mag;

  assign a_abs = a[WA-1] ? WA'(-a) : a;
  assign b_abs = b[WB-1] ? WB'(-b) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      am <= AW'(a_abs);
      bm <= BW'(b_abs);
      sg <= a[WA-1] ^ b[WB-1];
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_cell
    logic [AW-1:0]  am_i;
    logic [BW-1:0]  bm_i;
    logic           sg_i;
    logic [ACW-1:0] acc_i;
    logic [AW-1:0]  ev_c;
    logic [AW-1:0]  od_c;

    if (j == 0) begin : g_first
      assign am_i  = am;
      assign bm_i  = bm;
      assign sg_i  = sg;
      assign acc_i = '0;
    end else begin : g_next
      assign am_i  = am_s[j-1];
      assign bm_i  = bm_s[j-1];
      assign sg_i  = sg_s[j-1];
      assign acc_i = acc[j-1] + (ACW'(ev[j-1]) << (32 * (j - 1)))
                              + (ACW'(od[j-1]) << (32 * j));
    end

    // even and odd slices of a do not overlap, so each row packs side by side
    always_comb begin
      for (int m = 0; m < NH; m++) begin
        ev_c[64*m +: 64] = am_i[64*m +: 32] * bm_i[32*j +: 32];
        od_c[64*m +: 64] = am_i[64*m+32 +: 32] * bm_i[32*j +: 32];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[j]  <= acc_i;
        ev[j]   <= ev_c;
        od[j]   <= od_c;
        sg_s[j] <= sg_i;
      end
    end

    if (j < NB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          am_s[j] <= am_i;
          bm_s[j] <= bm_i;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin  <= acc[NB-1] + (ACW'(ev[NB-1]) << (32 * (NB - 1)))
                        + (ACW'(od[NB-1]) << (32 * NB));
      sg_f <= sg_s[NB-1];
    end
  end

  assign mag = fin[PW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sg_f ? PW'(-mag) : mag;
    end
  end

endmodule

FILE: rtl/core/tcc_div_cell.sv
// One restoring-division step on three lanes sharing a divisor.
module tcc_div_cell import tcc_pkg::*; #(
  parameter int SH = 0
) (
  input  logic clk,
  input  logic en,
  input  div_t din,
  output div_t dout
);

  rem_t dv;
  div_t nx;

  assign dv = din.t << SH;

  always_comb begin
    nx.t = din.t;
    for (int k = 0; k < 3; k++) begin
      if (din.r[k] >= dv) begin
        nx.r[k] = din.r[k] - dv;
        nx.q[k] = {din.q[k][QB-2:0], 1'b1};
      end else begin
        nx.r[k] = din.r[k];
        nx.q[k] = {din.q[k][QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nx;
    end
  end

endmodule

FILE: rtl/core/triangle_circumcenter_top.sv
// Path from the accepting edge to m_tvalid: stages 2 to 53, then the output register.
// Throughput: one triangle per cycle; the pipeline stalls only while the output skid stage is full.
// The depth comes mostly from the 35-cell restoring divider chain and the two rows of sliced multipliers.
// Reset (rst, synchronous) clears the stage valid flags and the output buffer; data
// registers are not reset.
module triangle_circumcenter_top import tcc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
  // corner_c_x, corner_c_y, corner_c_z (32 bits each, lowest first)
  input  logic [287:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // center_x, center_y, center_z (32 bits each, lowest first)
  output logic [95:0]  m_tdata,
  // degenerate, saturated (lowest first)
  output logic [1:0]   m_tuser
);

  localparam int LAST = 53;        // last pipeline stage before the output buffer
  localparam int VW   = QW + 1;    // quotient plus corner

  // corner data kept alongside the arithmetic
  typedef struct packed {
    logic [2:0][CW-1:0] a;
    logic [2:0][DW-1:0] dab;   // b - a
    logic [2:0][DW-1:0] dac;   // c - a
  } pay_t;

  typedef struct packed {
    logic [2:0] neg;           // quotient sign per lane
    logic       deg;
  } side_t;

  typedef struct packed {
    logic [95:0] data;
    logic [1:0]  user;
  } res_t;

  function automatic logic [SQW-1:0] sq(input logic [DW-1:0] d);
    logic signed [2*DW-1:0] pr;
    pr = $signed(d) * $signed(d);
    return pr[SQW-1:0];
  endfunction

  logic                  en;
  logic [LAST:1]         vld;

  logic signed [CW-1:0]  ca [3];
  logic signed [CW-1:0]  cb [3];
  logic signed [CW-1:0]  cc [3];

  pay_t                  pay_d [1:10];
  logic [DW-1:0]         dbc1  [3];
  logic [SQW-1:0]        sab [3];
  logic [SQW-1:0]        sbc [3];
  logic [SQW-1:0]        sac [3];
  logic [LW-1:0]         lab3, lbc3, lca3;
  logic [LW-1:0]         lab4, lbc4, lca4;
  logic signed [SW-1:0]  sa4, sb4, sc4;
  logic signed [WW-1:0]  wa, wb, wc;
  logic signed [TW-1:0]  tot_d [11:15];
  logic signed [XPW-1:0] pxb [3];
  logic signed [XPW-1:0] pxc [3];
  logic signed [XW-1:0]  x16 [3];
  logic signed [TW-1:0]  t16;
  logic [TW-1:0]         t_abs;
  logic [XW-1:0]         x_abs [3];
  logic [2:0][CW-1:0]    a_d [11:53];
  side_t                 side_d [17:52];
  div_t                  dc [17:52];

  logic signed [QW-1:0]  q53 [3];
  logic [2:0]            ovf53;
  side_t                 side53;

  logic signed [VW-1:0]  v [3];
  logic [2:0]            sat_c;
  res_t                  res_c;

  logic                  out_v, sk_v;
  res_t                  out_d, sk_d;

  // the pipeline moves whenever the skid stage is free
  assign en       = !sk_v;
  assign s_tready = en;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca[k] = s_tdata[32*k +: 32];
      cb[k] = s_tdata[96 + 32*k +: 32];
      cc[k] = s_tdata[192 + 32*k +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:1], s_tvalid};
    end
  end

  // stages 1 to 4: differences, squares, edge lengths, weight factors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pay_d[1].a[k]   <= ca[k];
        pay_d[1].dab[k] <= DW'(cb[k]) - DW'(ca[k]);
        pay_d[1].dac[k] <= DW'(cc[k]) - DW'(ca[k]);
        dbc1[k]         <= DW'(cc[k]) - DW'(cb[k]);
        sab[k]          <= sq(pay_d[1].dab[k]);
        sbc[k]          <= sq(dbc1[k]);
        sac[k]          <= sq(pay_d[1].dac[k]);
      end
      for (int i = 2; i <= 10; i++) begin
        pay_d[i] <= pay_d[i-1];
      end
      lab3 <= LW'(sab[0]) + LW'(sab[1]) + LW'(sab[2]);
      lbc3 <= LW'(sbc[0]) + LW'(sbc[1]) + LW'(sbc[2]);
      lca3 <= LW'(sac[0]) + LW'(sac[1]) + LW'(sac[2]);
      lab4 <= lab3;
      lbc4 <= lbc3;
      lca4 <= lca3;
      sa4  <= SW'(lca3) - SW'(lbc3) + SW'(lab3);
      sb4  <= SW'(lbc3) - SW'(lca3) + SW'(lab3);
      sc4  <= SW'(lbc3) + SW'(lca3) - SW'(lab3);
    end
  end

  // stages 5 to 10: barycentric weights
  tcc_mul #(.WA(SW), .WB(LW + 1)) u_mul_wa (
    .clk(clk), .en(en), .a(sa4), .b($signed({1'b0, lbc4})), .p(wa)
  );
  tcc_mul #(.WA(SW), .WB(LW + 1)) u_mul_wb (
    .clk(clk), .en(en), .a(sb4), .b($signed({1'b0, lca4})), .p(wb)
  );
  tcc_mul #(.WA(SW), .WB(LW + 1)) u_mul_wc (
    .clk(clk), .en(en), .a(sc4), .b($signed({1'b0, lab4})), .p(wc)
  );

  // stages 11 to 15: numerator terms relative to corner a, total alongside
  for (genvar k = 0; k < 3; k++) begin : g_num
    tcc_mul #(.WA(WW), .WB(DW)) u_mul_b (
      .clk(clk), .en(en), .a(wb), .b($signed(pay_d[10].dab[k])), .p(pxb[k])
    );
    tcc_mul #(.WA(WW), .WB(DW)) u_mul_c (
      .clk(clk), .en(en), .a(wc), .b($signed(pay_d[10].dac[k])), .p(pxc[k])
    );
  end

  always_comb begin
    t_abs = t16[TW-1] ? TW'(-t16) : t16;
    for (int k = 0; k < 3; k++) begin
      x_abs[k] = x16[k][XW-1] ? XW'(-x16[k]) : x16[k];
    end
  end

  // stages 11 to 17: total, numerator, magnitudes for the divider
  always_ff @(posedge clk) begin
    if (en) begin
      tot_d[11] <= TW'(wa) + TW'(wb) + TW'(wc);
      for (int i = 12; i <= 15; i++) begin
        tot_d[i] <= tot_d[i-1];
      end
      a_d[11] <= pay_d[10].a;
      for (int i = 12; i <= 53; i++) begin
        a_d[i] <= a_d[i-1];
      end
      t16 <= tot_d[15];
      for (int k = 0; k < 3; k++) begin
        x16[k]             <= XW'(pxb[k]) + XW'(pxc[k]);
        dc[17].r[k]        <= RW'(x_abs[k]);
        dc[17].q[k]        <= '0;
        side_d[17].neg[k]  <= x16[k][XW-1] ^ t16[TW-1];
      end
      dc[17].t       <= RW'(t_abs);
      side_d[17].deg <= (t16 == '0);
      for (int i = 18; i <= 52; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  // stages 18 to 52: one quotient bit per cell, most significant first
  for (genvar i = 0; i < QB; i++) begin : g_div
    tcc_div_cell #(.SH(QB - 1 - i)) u_cell (
      .clk(clk), .en(en), .din(dc[17+i]), .dout(dc[18+i])
    );
  end

  // stage 53: floor quotient with sign; top quotient bit means out of range
  always_ff @(posedge clk) begin
    if (en) begin
      side53 <= side_d[52];
      for (int k = 0; k < 3; k++) begin
        ovf53[k] <= dc[52].q[k][QB-1];
        q53[k]   <= side_d[52].neg[k]
                    ? QW'(-QW'(dc[52].q[k])) - QW'(|dc[52].r[k])
                    : QW'(dc[52].q[k]);
      end
    end
  end

  // add corner a back, then clip; a degenerate triangle gives zero
  always_comb begin
    res_c = '0;
    for (int k = 0; k < 3; k++) begin
      v[k]     = VW'(q53[k]) + VW'($signed(a_d[53][k]));
      sat_c[k] = ovf53[k] || !((v[k][VW-1:CW-1] == '0) || (v[k][VW-1:CW-1] == '1));
      if (side53.deg) begin
        res_c.data[32*k +: 32] = '0;
      end else if (ovf53[k]) begin
        res_c.data[32*k +: 32] = side53.neg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (sat_c[k]) begin
        res_c.data[32*k +: 32] = v[k][VW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        res_c.data[32*k +: 32] = v[k][CW-1:0];
      end
    end
    res_c.user[0] = side53.deg;
    res_c.user[1] = !side53.deg && (|sat_c);
  end

  // output register plus skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (sk_v) begin
      if (m_tready) begin
        sk_v <= 1'b0;
      end
    end else if (vld[LAST]) begin
      if (!out_v || m_tready) begin
        out_v <= 1'b1;
      end else begin
        sk_v <= 1'b1;
      end
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v) begin
      if (m_tready) begin
        out_d <= sk_d;
      end
    end else if (vld[LAST]) begin
      if (!out_v || m_tready) begin
        out_d <= res_c;
      end else begin
        sk_d <= res_c;
      end
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_d.data;
  assign m_tuser  = out_d.user;

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
    else $error("degenerate result with nonzero centre or saturation");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    sk_v |-> out_v)
    else $error("skid stage holds a result while output register is empty");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("pipeline moved during stall");

endmodule
